// ===== hdl/pcfx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfx_pkg
// Shared types, register indexes, effect codes and arithmetic constants of
// the pixel color effect unit.
// ----------------------------------------------------------------------------
package pcfx_pkg;

    localparam int unsigned DEF_MAX_SIDE = 4096;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned SIDE_W  = 13;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned WDATA_W = 13;

    // Register indexes on the configuration port.
    localparam logic [ADDR_W-1:0] REG_EFFECT_MODE   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_FRAME_ENABLE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_BORDER_SIZE   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_CAPTION_SPACE = 3'd3;
    localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
    localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;

    typedef enum logic [2:0] {
        MODE_PASS    = 3'd0,
        MODE_GRAY    = 3'd1,
        MODE_SEPIA   = 3'd2,
        MODE_SUMMER  = 3'd3,
        MODE_WINTER  = 3'd4,
        MODE_INVERSE = 3'd5
    } mode_t;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd100;

    // Sepia matrix in Q10, rows are output red, green, blue; columns r, g, b.
    localparam int unsigned COEF_W = 10;
    localparam int unsigned PROD_W = COEF_W + CHAN_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam logic [COEF_W-1:0] SEPIA_COEF [3][3] = '{
        '{10'd402, 10'd787, 10'd194},
        '{10'd356, 10'd702, 10'd172},
        '{10'd279, 10'd547, 10'd134}
    };

    // (r + g + b) / 3 as (sum * 683) >> 11, exact for sums up to 765.
    localparam int unsigned        GSUM_W      = 10;
    localparam logic [GSUM_W-1:0]  GRAY_RECIP  = 10'd683;
    localparam int unsigned        GRAY_SHIFT  = 11;
    localparam int unsigned        GPROD_W     = 2 * GSUM_W;

    localparam logic [CHAN_W-1:0] CHAN_HIGH = 8'd205;
    localparam logic [CHAN_W-1:0] CHAN_LOW  = 8'd50;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

    typedef struct packed {
        logic [2:0]         effect_mode;
        logic               frame_enable;
        logic [COORD_W-1:0] border_size;
        logic [COORD_W-1:0] caption_space;
        logic [SIDE_W-1:0]  image_width;
        logic [SIDE_W-1:0]  image_height;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // Load enables of the first two pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
    } pipe_en_t;

endpackage
`default_nettype wire

// ===== hdl/pcfx_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfx_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pcfx_cfg_regs
    import pcfx_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [ADDR_W-1:0]  cfg_addr,
    input  wire logic [WDATA_W-1:0] cfg_wdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EFFECT_MODE:   cfg_next.effect_mode   = cfg_wdata[2:0];
                REG_FRAME_ENABLE:  cfg_next.frame_enable  = cfg_wdata[0];
                REG_BORDER_SIZE:   cfg_next.border_size   = cfg_wdata[COORD_W-1:0];
                REG_CAPTION_SPACE: cfg_next.caption_space = cfg_wdata[COORD_W-1:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_wdata[SIDE_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_wdata[SIDE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.effect_mode   <= MODE_PASS;
            cfg_reg.frame_enable  <= 1'b0;
            cfg_reg.border_size   <= '0;
            cfg_reg.caption_space <= '0;
            cfg_reg.image_width   <= SIDE_RESET;
            cfg_reg.image_height  <= SIDE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hdl/pcfx_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfx_window
// Two-stage window test: decides whether a pixel lies inside the picture
// area that the border and caption leave free.
// ----------------------------------------------------------------------------
module pcfx_window
    import pcfx_pkg::*;
#(
    parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
)
(
    input  wire logic               aclk,
    input  wire pipe_en_t           en,
    input  wire cfg_t               cfg,
    input  wire logic [COORD_W-1:0] pixel_row,
    input  wire logic [COORD_W-1:0] pixel_col,
    output logic                    in_win
);

    // Largest usable side; a 13-bit register never exceeds the clamp above it.
    localparam int unsigned SIDE_MAX  = (1 << SIDE_W) - 1;
    localparam int unsigned SIDE_CAP  = (MAX_SIDE > SIDE_MAX) ? SIDE_MAX : MAX_SIDE;
    localparam logic [SIDE_W-1:0] SIDE_CAP_V = SIDE_CAP[SIDE_W-1:0];
    localparam int unsigned ROW_END_W = COORD_W + 2;

    logic                  row_lo_ok_reg;
    logic                  col_lo_ok_reg;
    logic [ROW_END_W-1:0]  row_end_reg;
    logic [SIDE_W-1:0]     col_end_reg;
    logic                  in_win_reg;
    logic [SIDE_W-1:0]     width_sat;
    logic [SIDE_W-1:0]     height_sat;

    assign width_sat  = (cfg.image_width  > SIDE_CAP_V) ? SIDE_CAP_V : cfg.image_width;
    assign height_sat = (cfg.image_height > SIDE_CAP_V) ? SIDE_CAP_V : cfg.image_height;

    // The upper bounds are tested as row + border + caption < height and
    // col + border < width, which also covers windows whose bounds cross.
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            row_lo_ok_reg <= pixel_row >= cfg.border_size;
            col_lo_ok_reg <= pixel_col >= cfg.border_size;
            row_end_reg   <= {2'b00, pixel_row} + {2'b00, cfg.border_size}
                             + {2'b00, cfg.caption_space};
            col_end_reg   <= {1'b0, pixel_col} + {1'b0, cfg.border_size};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            in_win_reg <= row_lo_ok_reg && col_lo_ok_reg
                          && (row_end_reg < {1'b0, height_sat})
                          && (col_end_reg < width_sat);
        end
    end

    assign in_win = in_win_reg;

endmodule
`default_nettype wire

// ===== hdl/pcfx_color.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfx_color
// Two-stage color arithmetic: sepia matrix products and sums with
// saturation, and the gray average by reciprocal multiplication.
// ----------------------------------------------------------------------------
module pcfx_color
    import pcfx_pkg::*;
(
    input  wire logic aclk,
    input  wire pipe_en_t en,
    input  wire rgb_t pix_in,
    output rgb_t      pix_q,
    output rgb_t      sepia_q,
    output logic [CHAN_W-1:0] gray_q
);

    logic [PROD_W-1:0]  prod_reg [3][3];
    logic [GPROD_W-1:0] gray_prod_reg;
    rgb_t               pix1_reg;
    rgb_t               pix2_reg;
    logic [CHAN_W-1:0]  sepia_reg [3];
    logic [CHAN_W-1:0]  gray_reg;
    logic [CHAN_W-1:0]  chan_in [3];
    logic [GSUM_W-1:0]  gray_sum;
    logic [SUM_W-1:0]   sepia_sum [3];
    logic [SUM_W-11:0]  sepia_shift [3];

    assign chan_in[0] = pix_in.red;
    assign chan_in[1] = pix_in.green;
    assign chan_in[2] = pix_in.blue;
    assign gray_sum   = {2'b00, pix_in.red} + {2'b00, pix_in.green} + {2'b00, pix_in.blue};

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int o = 0; o < 3; o++) begin
                for (int i = 0; i < 3; i++) begin
                    prod_reg[o][i] <= SEPIA_COEF[o][i] * chan_in[i];
                end
            end
            gray_prod_reg <= gray_sum * GRAY_RECIP;
            pix1_reg      <= pix_in;
        end
    end

    always_comb begin
        for (int o = 0; o < 3; o++) begin
            sepia_sum[o]   = {1'b0, prod_reg[o][0]} + {1'b0, prod_reg[o][1]}
                             + {1'b0, prod_reg[o][2]};
            sepia_shift[o] = sepia_sum[o][SUM_W-1:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int o = 0; o < 3; o++) begin
                sepia_reg[o] <= sepia_shift[o][CHAN_W] ? CHAN_MAX
                                                       : sepia_shift[o][CHAN_W-1:0];
            end
            gray_reg <= gray_prod_reg[GRAY_SHIFT+CHAN_W-1:GRAY_SHIFT];
            pix2_reg <= pix1_reg;
        end
    end

    assign pix_q         = pix2_reg;
    assign sepia_q.red   = sepia_reg[0];
    assign sepia_q.green = sepia_reg[1];
    assign sepia_q.blue  = sepia_reg[2];
    assign gray_q        = gray_reg;

endmodule
`default_nettype wire

// ===== hdl/pixel_color_effect_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_effect_unit
// Per-pixel color effect (gray, sepia, summer, winter, inverse) with an
// optional white frame around the picture window.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the s_ stream, one word per pixel carrying its row,
// column and color; each accepted word gives exactly one word on the m_
// stream, in order. Settings are written through cfg_wr_en / cfg_addr /
// cfg_wdata while no pixel is in flight; writes to unused indexes are dropped.
// An accepted word passes two arithmetic stages (window compare and sepia
// products, then sums and saturation) and the output register that makes
// the final selection before it can be taken from the m_ stream.
// Throughput is one pixel per clock while the receiver takes words, set by
// those three stages, which each take a new word every cycle unless the
// output stalls.
// When the receiver stalls, the output word holds and the stages behind it
// keep filling until all three are full; only then does s_tready drop, and
// bubbles are squeezed out, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// register defaults: pass mode, no frame, zero border and caption, 100 x 100.
// ----------------------------------------------------------------------------
module pixel_color_effect_unit
    import pcfx_pkg::*;
#(
    parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
)
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration write port
    input  wire logic               cfg_wr_en,
    input  wire logic [ADDR_W-1:0]  cfg_addr,
    input  wire logic [WDATA_W-1:0] cfg_wdata,
    // Pixel input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [11:0] pixel_row, [23:12] pixel_col, [31:24] in_red,
    // [39:32] in_green, [47:40] in_blue
    input  wire logic [47:0]        s_tdata,
    // Pixel output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0]             m_tdata
);

    cfg_t              cfg;
    pipe_en_t          en;
    rgb_t              pix_in;
    rgb_t              pix_q;
    rgb_t              sepia_q;
    rgb_t              result;
    logic [CHAN_W-1:0] gray_q;
    logic              in_win;
    logic              v1_reg;
    logic              v2_reg;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic              ready1;
    logic              ready2;
    logic              ready3;

    pcfx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A stage takes a new word when it is empty or its word moves on.
    assign ready3   = !m_tvalid_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign en.s1    = ready1;
    assign en.s2    = ready2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                m_tvalid_reg <= v2_reg;
            end
        end
    end

    assign pix_in.red   = s_tdata[31:24];
    assign pix_in.green = s_tdata[39:32];
    assign pix_in.blue  = s_tdata[47:40];

    pcfx_window #(
        .MAX_SIDE (MAX_SIDE)
    ) u_window (
        .aclk      (aclk),
        .en        (en),
        .cfg       (cfg),
        .pixel_row (s_tdata[11:0]),
        .pixel_col (s_tdata[23:12]),
        .in_win    (in_win)
    );

    pcfx_color u_color (
        .aclk    (aclk),
        .en      (en),
        .pix_in  (pix_in),
        .pix_q   (pix_q),
        .sepia_q (sepia_q),
        .gray_q  (gray_q)
    );

    // Effect selection; the frame overrides whatever the effect produced.
    always_comb begin
        result = pix_q;
        case (cfg.effect_mode)
            MODE_GRAY: begin
                result.red   = gray_q;
                result.green = gray_q;
                result.blue  = gray_q;
            end
            MODE_SEPIA: begin
                if (in_win) begin
                    result = sepia_q;
                end
            end
            MODE_SUMMER: begin
                if (in_win) begin
                    result.red  = (pix_q.red < CHAN_HIGH) ? CHAN_HIGH : pix_q.red;
                    result.blue = (pix_q.blue > CHAN_LOW) ? CHAN_LOW : pix_q.blue;
                end
            end
            MODE_WINTER: begin
                if (in_win) begin
                    result.red  = (pix_q.red > CHAN_LOW) ? CHAN_LOW : pix_q.red;
                    result.blue = (pix_q.blue < CHAN_HIGH) ? CHAN_HIGH : pix_q.blue;
                end
            end
            MODE_INVERSE: begin
                if (in_win) begin
                    result.red   = ~pix_q.red;
                    result.green = ~pix_q.green;
                    result.blue  = ~pix_q.blue;
                end
            end
            default: begin
                result = pix_q;
            end
        endcase
        if (cfg.frame_enable && !in_win) begin
            result.red   = CHAN_MAX;
            result.green = CHAN_MAX;
            result.blue  = CHAN_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3) begin
            m_tdata_reg <= {result.blue, result.green, result.red};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== hdl/pcfx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcfx_checker
// Port-level checks of the pixel color effect unit, bound to the top level.
// ----------------------------------------------------------------------------
module pcfx_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // A stalled output word stays and keeps its value.
    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // With the receiver ready the pipeline never pushes back.
    a_no_backpressure : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled although output is ready");

    // While the receiver stays ready, an accepted word reaches the output.
    a_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not arrive after three cycles");

endmodule

bind pixel_color_effect_unit pcfx_checker u_pcfx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
